### rtl/core/gcdisp_pkg.sv
// Shared types and constants for the greedy change dispenser.
// Denomination tables, reciprocal constants for the greedy divide, and the
// command/status structs between controller and datapath. No dependencies.
package gcdisp_pkg;

	localparam int NUM_DENOMS   = 8;
	localparam int DENOM_IDX_W  = $clog2(NUM_DENOMS);
	localparam int DUE_W        = 14;
	localparam int PAID_W       = 8;
	localparam int CENTS_W      = 20;
	localparam int RET_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int FACE_W       = 11;
	localparam int RECIP_W      = 21;
	localparam int HALF_W       = CENTS_W / 2;
	localparam int PART_W       = HALF_W + RECIP_W;
	localparam int QSUM_W       = PART_W + HALF_W;
	localparam int SHIFT_W      = 5;
	localparam int PROD_W       = RET_W + FACE_W;
	localparam int DEFAULT_COUNT_WIDTH = 16;

	localparam logic [RET_W-1:0] RET_MAX = '1;

	// order: penny, nickel, dime, quarter, dollar, five, ten, twenty
	localparam logic [FACE_W-1:0] FACE_CENTS [NUM_DENOMS] = '{
		11'd1, 11'd5, 11'd10, 11'd25, 11'd100, 11'd500, 11'd1000, 11'd2000
	};

	localparam logic [PAID_W-1:0] INIT_STOCK [NUM_DENOMS] = '{
		8'd50, 8'd40, 8'd50, 8'd40, 8'd10, 8'd10, 8'd10, 8'd0
	};

	// floor(n / face) == (n * RECIP) >> RSHIFT for any 20-bit n
	localparam logic [RECIP_W-1:0] RECIP [NUM_DENOMS] = '{
		21'd1048576, 21'd1677722, 21'd1677722, 21'd1342178,
		21'd1342178, 21'd1073742, 21'd1073742, 21'd1073742
	};

	localparam logic [SHIFT_W-1:0] RSHIFT [NUM_DENOMS] = '{
		5'd20, 5'd23, 5'd24, 5'd25, 5'd27, 5'd29, 5'd30, 5'd31
	};

	typedef enum logic [STATUS_W-1:0] {
		ST_EXACT     = 2'd0,
		ST_UNDERPAID = 2'd1,
		ST_SHORT     = 2'd2
	} status_t;

	typedef struct packed {
		logic [DUE_W-1:0]                     due_cents;
		logic [NUM_DENOMS-1:0][PAID_W-1:0]    paid;
	} pay_t;

	typedef struct packed {
		logic [STATUS_W-1:0]                  status;
		logic [CENTS_W-1:0]                   change_cents;
		logic [NUM_DENOMS-1:0][RET_W-1:0]     ret;
		logic [CENTS_W-1:0]                   unpaid_cents;
	} res_t;

	typedef struct packed {
		logic                   load;
		logic                   acc;
		logic                   check;
		logic                   mul;
		logic                   quo;
		logic                   sub;
		logic                   emit;
		logic [DENOM_IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic underpaid;
	} sts_t;

endpackage

### rtl/core/gcdisp_if.sv
// Valid/ready channel interfaces for the payment and result words.
// Depends on gcdisp_pkg for field widths.
interface gcdisp_in_if import gcdisp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DUE_W-1:0]   due_cents;
	logic [PAID_W-1:0]  paid_penny;
	logic [PAID_W-1:0]  paid_nickel;
	logic [PAID_W-1:0]  paid_dime;
	logic [PAID_W-1:0]  paid_quarter;
	logic [PAID_W-1:0]  paid_dollar;
	logic [PAID_W-1:0]  paid_five;
	logic [PAID_W-1:0]  paid_ten;
	logic [PAID_W-1:0]  paid_twenty;

	modport source (
		output valid, due_cents, paid_penny, paid_nickel, paid_dime, paid_quarter,
			paid_dollar, paid_five, paid_ten, paid_twenty,
		input  ready
	);
	modport sink (
		input  valid, due_cents, paid_penny, paid_nickel, paid_dime, paid_quarter,
			paid_dollar, paid_five, paid_ten, paid_twenty,
		output ready
	);
endinterface

interface gcdisp_out_if import gcdisp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CENTS_W-1:0]  change_cents;
	logic [RET_W-1:0]    ret_penny;
	logic [RET_W-1:0]    ret_nickel;
	logic [RET_W-1:0]    ret_dime;
	logic [RET_W-1:0]    ret_quarter;
	logic [RET_W-1:0]    ret_dollar;
	logic [RET_W-1:0]    ret_five;
	logic [RET_W-1:0]    ret_ten;
	logic [RET_W-1:0]    ret_twenty;
	logic [CENTS_W-1:0]  unpaid_cents;

	modport source (
		output valid, status, change_cents, ret_penny, ret_nickel, ret_dime, ret_quarter,
			ret_dollar, ret_five, ret_ten, ret_twenty, unpaid_cents,
		input  ready
	);
	modport sink (
		input  valid, status, change_cents, ret_penny, ret_nickel, ret_dime, ret_quarter,
			ret_dollar, ret_five, ret_ten, ret_twenty, unpaid_cents,
		output ready
	);
endinterface

### rtl/core/greedy_change_dispenser_core.sv
// Greedy change dispenser, top level: channel wiring around gcdisp_ctrl and
// gcdisp_dp. Depends on gcdisp_pkg and the interfaces in gcdisp_if.
//
// Usage:
//   pay  - payment word: amount due in cents and counts of eight denominations.
//   res  - result word: status, change owed, pieces returned per denomination
//          and any change left unpaid for lack of stock.
//   One payment is handled at a time. The word is taken in the idle cycle,
//   then the paid total is summed one denomination per cycle, checked
//   against the amount due, and change is paid largest denomination first,
//   each denomination in steps: multiply by the reciprocal, quotient and
//   clamp to stock, subtract and update stock.
//   An underpayment skips the greedy walk and goes straight to the result.
//   The next payment is taken once the controller is back in idle; the
//   greedy walk takes most of the time of each payment.
//   The result register holds a word until res.ready takes it; a new payment
//   may be accepted and processed meanwhile and waits at the end until the
//   result register is free.
//   Reset loads the stock with 50,40,50,40,10,10,10,0 pieces, penny first,
//   and clears both channels.
module greedy_change_dispenser_core import gcdisp_pkg::*; #(
	parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	gcdisp_in_if.sink    pay,
	gcdisp_out_if.source res
);

	pay_t pay_word;
	res_t res_word;
	cmd_t cmd;
	sts_t sts;

	assign pay_word.due_cents = pay.due_cents;
	assign pay_word.paid[0]   = pay.paid_penny;
	assign pay_word.paid[1]   = pay.paid_nickel;
	assign pay_word.paid[2]   = pay.paid_dime;
	assign pay_word.paid[3]   = pay.paid_quarter;
	assign pay_word.paid[4]   = pay.paid_dollar;
	assign pay_word.paid[5]   = pay.paid_five;
	assign pay_word.paid[6]   = pay.paid_ten;
	assign pay_word.paid[7]   = pay.paid_twenty;

	assign res.status       = res_word.status;
	assign res.change_cents = res_word.change_cents;
	assign res.ret_penny    = res_word.ret[0];
	assign res.ret_nickel   = res_word.ret[1];
	assign res.ret_dime     = res_word.ret[2];
	assign res.ret_quarter  = res_word.ret[3];
	assign res.ret_dollar   = res_word.ret[4];
	assign res.ret_five     = res_word.ret[5];
	assign res.ret_ten      = res_word.ret[6];
	assign res.ret_twenty   = res_word.ret[7];
	assign res.unpaid_cents = res_word.unpaid_cents;

	gcdisp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pay.valid),
		.in_ready  (pay.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gcdisp_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.pay_word (pay_word),
		.cmd      (cmd),
		.sts      (sts),
		.res_word (res_word)
	);

endmodule

### rtl/core/gcdisp_dp.sv
// Datapath: payment total, stock counts, reciprocal divide and change registers.
// Driven by gcdisp_ctrl through cmd_t; depends on gcdisp_pkg.
module gcdisp_dp import gcdisp_pkg::*; #(
	parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  pay_t pay_word,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t res_word
);

	localparam int SUM_W = COUNT_WIDTH + 1;
	localparam int CAP_W = (COUNT_WIDTH > RET_W) ? COUNT_WIDTH : RET_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [DUE_W-1:0]       due_q;
	logic [PAID_W-1:0]      paid_q [NUM_DENOMS];
	logic [CENTS_W-1:0]     total_q;
	logic [CENTS_W-1:0]     rem_q;
	logic [CENTS_W-1:0]     change_q;
	logic                   underpaid_q;
	logic [PART_W-1:0]      phi_q;
	logic [PART_W-1:0]      plo_q;
	logic [COUNT_WIDTH-1:0] eff_q;
	logic [RET_W-1:0]       cap_q;
	logic [RET_W-1:0]       take_q;
	logic [COUNT_WIDTH-1:0] stock_q [NUM_DENOMS];
	logic [RET_W-1:0]       ret_q [NUM_DENOMS];

	logic [PAID_W+FACE_W-1:0] pay_prod;
	logic [SUM_W-1:0]         dep_sum;
	logic [COUNT_WIDTH-1:0]   eff;
	logic [RET_W-1:0]         cap;
	logic [QSUM_W-1:0]        qsum;
	logic [CENTS_W-1:0]       quot;
	logic [PROD_W-1:0]        paid_out;

	assign pay_prod = (PAID_W+FACE_W)'(paid_q[cmd.idx]) * (PAID_W+FACE_W)'(FACE_CENTS[cmd.idx]);
	assign sts.underpaid = total_q < CENTS_W'(due_q);

	// deposit with saturation, then cap at what one word can report
	always_comb begin
		dep_sum = SUM_W'(stock_q[cmd.idx]) + SUM_W'(paid_q[cmd.idx]);
		eff     = dep_sum[COUNT_WIDTH] ? COUNT_MAX : dep_sum[COUNT_WIDTH-1:0];
		cap     = (CAP_W'(eff) > CAP_W'(RET_MAX)) ? RET_MAX : RET_W'(CAP_W'(eff));
	end

	assign qsum     = {phi_q, {HALF_W{1'b0}}} + QSUM_W'(plo_q);
	assign quot     = CENTS_W'(qsum >> RSHIFT[cmd.idx]);
	assign paid_out = PROD_W'(take_q) * PROD_W'(FACE_CENTS[cmd.idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOMS; i++) begin
				stock_q[i] <= COUNT_WIDTH'(INIT_STOCK[i]);
			end
		end else if (cmd.sub) begin
			stock_q[cmd.idx] <= COUNT_WIDTH'(CAP_W'(eff_q) - CAP_W'(take_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			due_q   <= pay_word.due_cents;
			total_q <= '0;
			for (int i = 0; i < NUM_DENOMS; i++) begin
				paid_q[i] <= pay_word.paid[i];
			end
		end
		if (cmd.acc) begin
			total_q <= total_q + CENTS_W'(pay_prod);
		end
		if (cmd.check) begin
			rem_q       <= total_q - CENTS_W'(due_q);
			change_q    <= total_q - CENTS_W'(due_q);
			underpaid_q <= sts.underpaid;
		end
		if (cmd.mul) begin
			phi_q <= PART_W'(rem_q[CENTS_W-1:HALF_W]) * PART_W'(RECIP[cmd.idx]);
			plo_q <= PART_W'(rem_q[HALF_W-1:0]) * PART_W'(RECIP[cmd.idx]);
			eff_q <= eff;
			cap_q <= cap;
		end
		if (cmd.quo) begin
			take_q <= (quot > CENTS_W'(cap_q)) ? cap_q : RET_W'(quot);
		end
		if (cmd.sub) begin
			// take * face never exceeds rem, so the low bits are exact
			rem_q           <= CENTS_W'(PROD_W'(rem_q) - paid_out);
			ret_q[cmd.idx]  <= take_q;
		end
		if (cmd.emit) begin
			if (underpaid_q) begin
				res_word.status       <= ST_UNDERPAID;
				res_word.change_cents <= '0;
				res_word.ret          <= '0;
				res_word.unpaid_cents <= '0;
			end else begin
				res_word.status       <= (rem_q == '0) ? ST_EXACT : ST_SHORT;
				res_word.change_cents <= change_q;
				for (int i = 0; i < NUM_DENOMS; i++) begin
					res_word.ret[i] <= ret_q[i];
				end
				res_word.unpaid_cents <= rem_q;
			end
		end
	end

endmodule

### rtl/core/gcdisp_ctrl.sv
// Controller: sequences the total walk, the underpayment check and the
// three-phase greedy step per denomination. Depends on gcdisp_pkg.
module gcdisp_ctrl import gcdisp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOTAL,
		S_CHECK,
		S_MUL,
		S_QUO,
		S_SUB,
		S_EMIT
	} state_t;

	localparam logic [DENOM_IDX_W-1:0] IDX_LAST = DENOM_IDX_W'(NUM_DENOMS - 1);

	state_t                 state_q;
	logic [DENOM_IDX_W-1:0] idx_q;
	logic                   out_valid_q;
	logic                   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		cmd.idx   = idx_q;
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.acc   = (state_q == S_TOTAL);
		cmd.check = (state_q == S_CHECK);
		cmd.mul   = (state_q == S_MUL);
		cmd.quo   = (state_q == S_QUO);
		cmd.sub   = (state_q == S_SUB);
		cmd.emit  = (state_q == S_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word replaces one taken in the same cycle
			out_valid_q <= cmd.emit || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						state_q <= S_TOTAL;
					end
				end
				S_TOTAL: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CHECK: begin
					// greedy walk starts at the largest face value
					idx_q   <= IDX_LAST;
					state_q <= sts.underpaid ? S_EMIT : S_MUL;
				end
				S_MUL: state_q <= S_QUO;
				S_QUO: state_q <= S_SUB;
				S_SUB: begin
					if (idx_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_MUL;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new payment taken while one is in progress");

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q || out_ready)
		else $error("result word overwritten before it was taken");

	a_reject_skips_greedy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK && sts.underpaid |=> state_q == S_EMIT)
		else $error("underpayment did not go straight to the result");

	a_greedy_ends_at_penny: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUB && idx_q == '0 |=> state_q == S_EMIT && $stable(idx_q))
		else $error("greedy walk did not finish after the smallest coin");

	a_total_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_TOTAL) |-> idx_q == '0)
		else $error("total walk did not start at the first denomination");

endmodule

### verif/greedy_change_dispenser_core_tb.sv
// Self-checking testbench for greedy_change_dispenser_core: drives payment words,
// predicts each result word from a local copy of the drawer stock and checks it.
// Depends on gcdisp_pkg, the channel interfaces in gcdisp_if and the core RTL.
module greedy_change_dispenser_core_tb;
	import gcdisp_pkg::*;

	localparam int COUNT_W = DEFAULT_COUNT_WIDTH;
	localparam longint unsigned STOCK_MAX = (64'd1 << COUNT_W) - 1;
	localparam int DUE_MAX = (1 << DUE_W) - 1;
	localparam int PAID_MAX = (1 << PAID_W) - 1;
	localparam int SETTLE_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	gcdisp_in_if  pay_ch ();
	gcdisp_out_if res_ch ();

	greedy_change_dispenser_core #(.COUNT_WIDTH(COUNT_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pay    (pay_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	logic [COUNT_W-1:0] drawer_stock [NUM_DENOMS];
	res_t               pending_payouts [$];
	int unsigned        mismatch_count = 0;
	int unsigned        words_checked = 0;

	// sender burst/gap shaping and receiver stall pattern, tuned per test
	int unsigned burst_left = 0;
	int unsigned tx_gap_max = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned rx_stall_max = 1;

	function automatic longint unsigned paid_value(input pay_t p);
		longint unsigned total;
		total = 0;
		for (int d = 0; d < NUM_DENOMS; d++)
			total += longint'(p.paid[d]) * FACE_CENTS[d];
		return total;
	endfunction

	// Deposits the coins and walks the change out, largest denomination first; an underpayment returns only its status.
	function automatic res_t dispense(input pay_t p);
		res_t            r;
		longint unsigned total, rem, take, level;
		r = '0;
		total = paid_value(p);
		if (total < p.due_cents) begin
			r.status = ST_UNDERPAID;
			return r;
		end
		for (int d = 0; d < NUM_DENOMS; d++) begin
			level = longint'(drawer_stock[d]) + p.paid[d];
			drawer_stock[d] = (level > STOCK_MAX) ? COUNT_W'(STOCK_MAX) : COUNT_W'(level);
		end
		rem = total - p.due_cents;
		r.change_cents = CENTS_W'(rem);
		for (int d = NUM_DENOMS - 1; d >= 0; d--) begin
			take = rem / FACE_CENTS[d];
			if (take > drawer_stock[d])
				take = drawer_stock[d];
			if (take > RET_MAX)
				take = RET_MAX;
			drawer_stock[d] = drawer_stock[d] - COUNT_W'(take);
			rem = rem - take * FACE_CENTS[d];
			r.ret[d] = RET_W'(take);
		end
		r.unpaid_cents = CENTS_W'(rem);
		r.status = (rem == 0) ? ST_EXACT : ST_SHORT;
		return r;
	endfunction

	function automatic pay_t make_payment(input int due, input int penny, input int nickel,
			input int dime, input int quarter, input int dollar, input int five,
			input int ten, input int twenty);
		pay_t p;
		p.due_cents = DUE_W'(due);
		p.paid[0] = PAID_W'(penny);
		p.paid[1] = PAID_W'(nickel);
		p.paid[2] = PAID_W'(dime);
		p.paid[3] = PAID_W'(quarter);
		p.paid[4] = PAID_W'(dollar);
		p.paid[5] = PAID_W'(five);
		p.paid[6] = PAID_W'(ten);
		p.paid[7] = PAID_W'(twenty);
		return p;
	endfunction

	// Mostly payments that cover the amount due, with underpayments and raw noise mixed in.
	function automatic pay_t random_payment();
		pay_t            p;
		longint unsigned total;
		int unsigned     kind, slack;
		kind = $urandom_range(0, 99);
		for (int d = 0; d < NUM_DENOMS; d++) begin
			if (kind < 15)
				p.paid[d] = PAID_W'($urandom_range(0, PAID_MAX));
			else case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: p.paid[d] = PAID_W'($urandom_range(0, 3));
				6, 7:             p.paid[d] = PAID_W'($urandom_range(0, 20));
				8:                p.paid[d] = PAID_W'($urandom_range(0, PAID_MAX));
				default:          p.paid[d] = $urandom_range(0, 1) ? PAID_W'(PAID_MAX) : '0;
			endcase
		end
		total = paid_value(p);
		if (kind < 15 || total > DUE_MAX) begin
			p.due_cents = DUE_W'($urandom_range(0, DUE_MAX));
		end else if (kind < 30 && total < DUE_MAX) begin
			p.due_cents = DUE_W'($urandom_range(int'(total) + 1, DUE_MAX));
		end else begin
			case ($urandom_range(0, 3))
				0:       slack = 0;
				1:       slack = $urandom_range(0, (total < 99) ? int'(total) : 99);
				default: slack = $urandom_range(0, int'(total));
			endcase
			p.due_cents = DUE_W'(total - slack);
		end
		return p;
	endfunction

	task automatic send_payment(input pay_t p);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap != 0) begin
				@(negedge clk);
				pay_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		pay_ch.due_cents    <= p.due_cents;
		pay_ch.paid_penny   <= p.paid[0];
		pay_ch.paid_nickel  <= p.paid[1];
		pay_ch.paid_dime    <= p.paid[2];
		pay_ch.paid_quarter <= p.paid[3];
		pay_ch.paid_dollar  <= p.paid[4];
		pay_ch.paid_five    <= p.paid[5];
		pay_ch.paid_ten     <= p.paid[6];
		pay_ch.paid_twenty  <= p.paid[7];
		pay_ch.valid        <= 1'b1;
		do @(posedge clk); while (!pay_ch.ready);
		pending_payouts.insert(pending_payouts.size(), dispense(p));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		pay_ch.valid <= 1'b0;
		while (pending_payouts.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at word %0d: %s", words_checked, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		res_t             want;
		logic [RET_W-1:0] got_ret [NUM_DENOMS];
		got_ret = '{res_ch.ret_penny, res_ch.ret_nickel, res_ch.ret_dime, res_ch.ret_quarter,
			res_ch.ret_dollar, res_ch.ret_five, res_ch.ret_ten, res_ch.ret_twenty};
		if (pending_payouts.size() == 0) begin
			report_mismatch("result word with no payment pending");
		end else begin
			want = pending_payouts.pop_front();
			if (res_ch.status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d", res_ch.status, want.status));
			if (res_ch.change_cents !== want.change_cents)
				report_mismatch($sformatf("change_cents got %0d want %0d",
					res_ch.change_cents, want.change_cents));
			for (int d = 0; d < NUM_DENOMS; d++)
				if (got_ret[d] !== want.ret[d])
					report_mismatch($sformatf("returned pieces of %0d-cent got %0d want %0d",
						FACE_CENTS[d], got_ret[d], want.ret[d]));
			if (res_ch.unpaid_cents !== want.unpaid_cents)
				report_mismatch($sformatf("unpaid_cents got %0d want %0d",
					res_ch.unpaid_cents, want.unpaid_cents));
		end
		words_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			check_result();
	end

	// receiver: ready high except for stalls of random length
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < rx_stall_pct)
					stall_left = $urandom_range(1, rx_stall_max);
			end
		end
	end

	task automatic test_extremes();
		tx_gap_max = 6;
		rx_stall_pct = 20;
		rx_stall_max = 8;
		send_payment(make_payment(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_payment(make_payment(0, 255, 255, 255, 255, 255, 255, 255, 255));
		send_payment(make_payment(DUE_MAX, 3, 1, 0, 3, 3, 0, 0, 8));
		send_payment(make_payment(11999, 0, 0, 0, 0, 0, 0, 0, 6));
		send_payment(make_payment(0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_payment(make_payment(1, 0, 0, 0, 0, 0, 0, 0, 255));
	endtask

	task automatic test_underpayment();
		send_payment(make_payment(1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_payment(make_payment(DUE_MAX, 2, 1, 0, 3, 3, 0, 0, 8));
		send_payment(make_payment(DUE_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
		send_payment(make_payment(11999, 255, 0, 0, 0, 0, 0, 0, 5));
	endtask

	// four cents of change per word, each paid out in pennies from the drawer
	task automatic test_stock_short();
		repeat (14)
			send_payment(make_payment(1, 0, 1, 0, 0, 0, 0, 0, 0));
		send_payment(make_payment(0, 0, 0, 1, 0, 0, 0, 0, 0));
		wait_for_results();
		send_payment(make_payment(255, 255, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_payments();
		for (int n = 0; n < 420; n++) begin
			if (n == 0) begin
				tx_gap_max = 20;
				rx_stall_pct = 10;
				rx_stall_max = 30;
			end else if (n == 140) begin
				tx_gap_max = 0;
				rx_stall_pct = 0;
			end else if (n == 200) begin
				wait_for_results();
			end else if (n == 280) begin
				tx_gap_max = 40;
				rx_stall_pct = 30;
				rx_stall_max = 5;
			end
			send_payment(random_payment());
		end
	endtask

	// payments in the four small coins, mostly exact, fill those counts up to saturation
	task automatic test_stock_saturation();
		int unsigned slack;
		tx_gap_max = 0;
		rx_stall_pct = 0;
		for (int n = 0; n < 270; n++) begin
			if (n == 130) begin
				tx_gap_max = 10;
				rx_stall_pct = 15;
				rx_stall_max = 12;
			end
			slack = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
			send_payment(make_payment(10455 - slack, 255, 255, 255, 255, 0, 0, 0, 0));
		end
		send_payment(make_payment(0, 255, 0, 0, 0, 0, 0, 0, 0));
		repeat (3)
			send_payment(make_payment(0, 255, 255, 255, 255, 255, 255, 255, 255));
		send_payment(make_payment($urandom_range(0, DUE_MAX), 0, 0, 0, 0, 0, 0, 0, 255));
	endtask

	initial begin
		for (int d = 0; d < NUM_DENOMS; d++)
			drawer_stock[d] = COUNT_W'(INIT_STOCK[d]);
		arst_n              <= 1'b0;
		pay_ch.valid        <= 1'b0;
		pay_ch.due_cents    <= '0;
		pay_ch.paid_penny   <= '0;
		pay_ch.paid_nickel  <= '0;
		pay_ch.paid_dime    <= '0;
		pay_ch.paid_quarter <= '0;
		pay_ch.paid_dollar  <= '0;
		pay_ch.paid_five    <= '0;
		pay_ch.paid_ten     <= '0;
		pay_ch.paid_twenty  <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_underpayment();
		test_stock_short();
		test_random_payments();
		test_stock_saturation();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS greedy_change_dispenser_core");
		else
			$display("FAIL greedy_change_dispenser_core");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL greedy_change_dispenser_core");
		$finish;
	end

endmodule
